// ----- src/cnls_pkg.sv -----
// Package with the item types, codes and the init sequence table of the LCD nibble sequencer.
package cnls_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  typedef enum logic [2:0] {
    ACT_INIT   = 3'd0,
    ACT_CMD    = 3'd1,
    ACT_DATA   = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_CURSOR = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    CFG_ENABLE_PULSE = 2'd0,
    CFG_NIBBLE_GAP   = 2'd1,
    CFG_POWER_UP     = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_e;

  localparam logic [7:0] CmdClear   = 8'h01;
  localparam logic [7:0] CmdSetAddr = 8'h80;
  localparam logic [6:0] Row1Base   = 7'h40;

  localparam logic [3:0] InitLastStep = 4'd13;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] byte_value;
    logic [5:0] column;
    logic [1:0] row;
  } in_item_t;

  typedef struct packed {
    logic       register_select;
    logic [3:0] nibble;
    logic [7:0] wait_before_ms;
    logic [8:0] wait_after_ms;
    logic       last;
  } out_item_t;

  // One request as the back end sees it: a whole init sequence or one byte.
  typedef struct packed {
    logic       is_init;
    logic       register_select;
    logic [7:0] byte_value;
  } job_t;

  typedef struct packed {
    logic [7:0] nibble_gap_ms;
    logic [7:0] power_up_ms;
  } timing_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic [7:0] extra_ms;
    logic       last;
  } init_step_t;

  function automatic init_step_t init_step(input logic [3:0] step);
    init_step_t s;
    s = '{nibble: 4'h0, extra_ms: 8'd0, last: 1'b0};
    case (step)
      4'd0:  s = '{nibble: 4'h3, extra_ms: 8'd5,   last: 1'b0};
      4'd1:  s = '{nibble: 4'h3, extra_ms: 8'd150, last: 1'b0};
      4'd2:  s = '{nibble: 4'h3, extra_ms: 8'd150, last: 1'b0};
      4'd3:  s = '{nibble: 4'h2, extra_ms: 8'd150, last: 1'b0};
      4'd4:  s = '{nibble: 4'h2, extra_ms: 8'd0,   last: 1'b0};
      4'd5:  s = '{nibble: 4'h8, extra_ms: 8'd0,   last: 1'b0};
      4'd6:  s = '{nibble: 4'h0, extra_ms: 8'd0,   last: 1'b0};
      4'd7:  s = '{nibble: 4'h8, extra_ms: 8'd0,   last: 1'b0};
      4'd8:  s = '{nibble: 4'h0, extra_ms: 8'd0,   last: 1'b0};
      4'd9:  s = '{nibble: 4'h1, extra_ms: 8'd2,   last: 1'b0};
      4'd10: s = '{nibble: 4'h0, extra_ms: 8'd0,   last: 1'b0};
      4'd11: s = '{nibble: 4'h6, extra_ms: 8'd0,   last: 1'b0};
      4'd12: s = '{nibble: 4'h0, extra_ms: 8'd0,   last: 1'b0};
      4'd13: s = '{nibble: 4'hC, extra_ms: 8'd0,   last: 1'b1};
      default: s = '{nibble: 4'h0, extra_ms: 8'd0, last: 1'b1};
    endcase
    return s;
  endfunction

endpackage

// ----- src/cnls_front.sv -----
// Front end: accepts request items, drops unknown actions and turns the rest into jobs.
module cnls_front (
  input  logic              in_valid_i,
  input  cnls_pkg::in_item_t in_item_i,
  output logic              in_stall_o,
  input  logic              q_full_i,
  output logic              q_push_o,
  output cnls_pkg::job_t    q_job_o
);
  import cnls_pkg::*;

  logic [6:0] cursor_addr;
  logic       known;

  assign in_stall_o  = q_full_i;
  assign cursor_addr = ((in_item_i.row == 2'd1) ? Row1Base : 7'h00) + {1'b0, in_item_i.column};

  always_comb begin
    known   = 1'b1;
    q_job_o = '{is_init: 1'b0, register_select: 1'b0, byte_value: in_item_i.byte_value};
    case (in_item_i.action)
      ACT_INIT:   q_job_o.is_init = 1'b1;
      ACT_CMD:    q_job_o.byte_value = in_item_i.byte_value;
      ACT_DATA:   q_job_o.register_select = 1'b1;
      ACT_CLEAR:  q_job_o.byte_value = CmdClear;
      ACT_CURSOR: q_job_o.byte_value = CmdSetAddr | {1'b0, cursor_addr};
      default:    known = 1'b0;
    endcase
  end

  assign q_push_o = in_valid_i && !q_full_i && known;

endmodule

// ----- src/cnls_queue.sv -----
// Small job queue between the front end and the nibble sequencer.
module cnls_queue #(
  parameter int unsigned Depth = cnls_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cnls_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output cnls_pkg::job_t pop_job_o,
  output logic           empty_o
);
  import cnls_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o    = (count_q == CntFull);
  assign empty_o   = (count_q == '0);
  assign pop_job_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ----- src/cnls_back.sv -----
// Back end: emits a job's nibble writes into the output register, one per cycle unless stalled.
module cnls_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cnls_pkg::timing_t   timing_i,
  input  logic                q_empty_i,
  input  cnls_pkg::job_t      q_job_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  output cnls_pkg::out_item_t out_item_o,
  input  logic                out_stall_i
);
  import cnls_pkg::*;

  back_state_e state_q, state_d;
  job_t        job_q, job_d;
  logic [3:0]  step_q, step_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;
  init_step_t  ist;
  logic        slot_free;
  logic [7:0]  extra;
  logic        is_last;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign ist         = init_step(step_q);

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    extra       = 8'd0;
    is_last     = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          job_d   = q_job_i;
          step_d  = '0;
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (slot_free) begin
          out_d.register_select = job_q.register_select;
          out_d.wait_before_ms  = 8'd0;
          if (job_q.is_init) begin
            out_d.nibble = ist.nibble;
            extra        = ist.extra_ms;
            is_last      = (step_q == InitLastStep);
            if (step_q == '0) begin
              out_d.wait_before_ms = timing_i.power_up_ms;
            end
          end else begin
            out_d.nibble = step_q[0] ? job_q.byte_value[3:0] : job_q.byte_value[7:4];
            is_last      = step_q[0];
          end
          out_d.wait_after_ms = {1'b0, timing_i.nibble_gap_ms} + {1'b0, extra};
          out_d.last          = is_last;
          out_valid_d         = 1'b1;
          step_d              = step_q + 1'b1;
          if (is_last) begin
            state_d = BK_IDLE;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    out_q <= out_d;
  end

endmodule

// ----- src/char_lcd_nibble_sequencer_core.sv -----
// Top level of the character LCD nibble sequencer: config registers, front end, queue, back end.
//
//   channel | handshake              | payload
//   --------+------------------------+-----------------------------
//   in      | in_valid_i / in_stall_o | in_item_i (action, byte, cursor)
//   out     | out_valid_o / out_stall_i | out_item_o (one nibble write)
//   cfg     | cfg_we_i               | cfg_index_i, cfg_data_i
//
// The back end fetches a job from the queue while idle and then emits one nibble
// write per cycle unless the output stalls: 14 writes for init, 2 for every other request.
// Unknown actions are dropped by the front end and produce no item.
// A stalled output holds the back end; the queue keeps taking requests until full.
// Reset clears all control state and loads the timing registers with their defaults.
module char_lcd_nibble_sequencer_core #(
  parameter int unsigned QueueDepth = cnls_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  cnls_pkg::in_item_t  in_item_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output cnls_pkg::out_item_t out_item_o,
  input  logic                out_stall_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i
);
  import cnls_pkg::*;

  logic [7:0] enable_pulse_ms_q, nibble_gap_ms_q, power_up_ms_q;
  logic       q_push, q_pop, q_full, q_empty;
  job_t       push_job, pop_job;
  timing_t    timing;

  // The enable pulse width is held for the display driver; no item field carries it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_pulse_ms_q <= 8'd1;
      nibble_gap_ms_q   <= 8'd100;
      power_up_ms_q     <= 8'd20;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ENABLE_PULSE: enable_pulse_ms_q <= cfg_data_i;
        CFG_NIBBLE_GAP:   nibble_gap_ms_q   <= cfg_data_i;
        CFG_POWER_UP:     power_up_ms_q     <= cfg_data_i;
        default:          enable_pulse_ms_q <= enable_pulse_ms_q;
      endcase
    end
  end

  assign timing = '{nibble_gap_ms: nibble_gap_ms_q, power_up_ms: power_up_ms_q};

  cnls_front u_front (
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (push_job)
  );

  cnls_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .pop_job_o  (pop_job),
    .empty_o    (q_empty)
  );

  cnls_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .timing_i    (timing),
    .q_empty_i   (q_empty),
    .q_job_i     (pop_job),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// ----- src/cnls_checker.sv -----
// Port-level checks for the nibble sequencer and the bind that attaches them.
module cnls_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input cnls_pkg::out_item_t out_item_o,
  input logic                out_stall_i
);
  import cnls_pkg::*;

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Output item dropped while stalled.");

  a_out_item_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("Output item changed while stalled.");

  a_power_up_only_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.wait_before_ms != 8'd0) |->
      !out_item_o.register_select && (out_item_o.nibble == 4'h3) && !out_item_o.last)
    else $error("Power-up wait on an item other than the first init nibble.");

  a_data_plain_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.register_select |->
      (out_item_o.wait_before_ms == 8'd0) && !out_item_o.wait_after_ms[8])
    else $error("Data nibble carries an extra delay.");

endmodule

bind char_lcd_nibble_sequencer_core cnls_checker u_cnls_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_item_o  (out_item_o),
  .out_stall_i (out_stall_i)
);

// ----- dv/tb_top.sv -----
// Self-checking testbench for the LCD nibble sequencer: predicts every nibble write and compares.
module tb_top;
  import cnls_pkg::*;

  localparam int unsigned MaxReports  = 10;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned StuckLimit  = 5000;
  localparam int unsigned IdlePct     = 17;

  localparam logic [1:0] CfgSpare       = 2'd3;
  localparam logic [3:0] WakeNibble     = 4'h3;
  localparam logic [3:0] Mode4BitNibble = 4'h2;
  localparam logic [7:0] FunctionSet    = 8'h28;
  localparam logic [7:0] DisplayOff     = 8'h08;
  localparam logic [7:0] EntryMode      = 8'h06;
  localparam logic [7:0] DisplayOn      = 8'h0C;
  localparam logic [7:0] FirstWakeMs    = 8'd5;
  localparam logic [7:0] WakeMs         = 8'd150;
  localparam logic [7:0] ClearMs        = 8'd2;

  class nibble_book;
    out_item_t   due_writes[$];
    logic [7:0]  pulse_ms;
    logic [7:0]  gap_ms;
    logic [7:0]  power_ms;
    int unsigned mismatches;

    function new();
      pulse_ms   = 8'd1;
      gap_ms     = 8'd100;
      power_ms   = 8'd20;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] value);
      case (idx)
        CFG_ENABLE_PULSE: pulse_ms = value;
        CFG_NIBBLE_GAP:   gap_ms = value;
        CFG_POWER_UP:     power_ms = value;
        default: ;
      endcase
    endfunction

    function void add_write(logic rs, logic [3:0] nib, logic [7:0] before_ms,
                            logic [7:0] extra_ms, logic is_last);
      out_item_t w;
      w.register_select = rs;
      w.nibble          = nib;
      w.wait_before_ms  = before_ms;
      w.wait_after_ms   = {1'b0, gap_ms} + {1'b0, extra_ms};
      w.last            = is_last;
      due_writes.push_back(w);
    endfunction

    function void add_byte(logic rs, logic [7:0] b, logic [7:0] extra_ms, logic is_last);
      add_write(rs, b[7:4], 8'd0, 8'd0, 1'b0);
      add_write(rs, b[3:0], 8'd0, extra_ms, is_last);
    endfunction

    function void note_request(in_item_t req);
      logic [6:0] addr;
      addr = ((req.row == 2'd1) ? Row1Base : 7'h00) + {1'b0, req.column};
      case (req.action)
        ACT_INIT: begin
          add_write(1'b0, WakeNibble, power_ms, FirstWakeMs, 1'b0);
          add_write(1'b0, WakeNibble, 8'd0, WakeMs, 1'b0);
          add_write(1'b0, WakeNibble, 8'd0, WakeMs, 1'b0);
          add_write(1'b0, Mode4BitNibble, 8'd0, WakeMs, 1'b0);
          add_byte(1'b0, FunctionSet, 8'd0, 1'b0);
          add_byte(1'b0, DisplayOff, 8'd0, 1'b0);
          add_byte(1'b0, CmdClear, ClearMs, 1'b0);
          add_byte(1'b0, EntryMode, 8'd0, 1'b0);
          add_byte(1'b0, DisplayOn, 8'd0, 1'b1);
        end
        ACT_CMD:    add_byte(1'b0, req.byte_value, 8'd0, 1'b1);
        ACT_DATA:   add_byte(1'b1, req.byte_value, 8'd0, 1'b1);
        ACT_CLEAR:  add_byte(1'b0, CmdClear, 8'd0, 1'b1);
        ACT_CURSOR: add_byte(1'b0, CmdSetAddr | {1'b0, addr}, 8'd0, 1'b1);
        default: ;
      endcase
    endfunction

    function void check_write(out_item_t got);
      out_item_t want;
      if (due_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("ERROR: unexpected write rs=%0d nib=%h before=%0d after=%0d last=%0d",
                   got.register_select, got.nibble, got.wait_before_ms,
                   got.wait_after_ms, got.last);
        return;
      end
      want = due_writes.pop_front();
      if (got.register_select !== want.register_select || got.nibble !== want.nibble ||
          got.wait_before_ms !== want.wait_before_ms ||
          got.wait_after_ms !== want.wait_after_ms || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("ERROR: write mismatch exp rs=%0d nib=%h before=%0d after=%0d last=%0d %s",
                   want.register_select, want.nibble, want.wait_before_ms,
                   want.wait_after_ms, want.last,
                   $sformatf("got rs=%0d nib=%h before=%0d after=%0d last=%0d",
                             got.register_select, got.nibble, got.wait_before_ms,
                             got.wait_after_ms, got.last));
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  in_item_t    in_item_i;
  logic        in_stall_o;
  logic        out_valid_o;
  out_item_t   out_item_o;
  logic        out_stall_i;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;

  nibble_book  book;
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  int unsigned stuck_cycles;

  char_lcd_nibble_sequencer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) book.check_write(out_item_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= StuckLimit) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  task automatic push_request(input in_item_t req);
    @(negedge clk_i);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    book.note_request(req);
  endtask

  task automatic make_request(input logic [2:0] act, input logic [7:0] b,
                              input logic [5:0] col, input logic [1:0] r);
    in_item_t req;
    req.action     = act;
    req.byte_value = b;
    req.column     = col;
    req.row        = r;
    push_request(req);
  endtask

  task automatic push_random_request();
    in_item_t    req;
    int unsigned pick;
    pick           = $urandom_range(99);
    req.byte_value = 8'($urandom);
    req.column     = 6'($urandom);
    req.row        = 2'($urandom);
    if (pick < 8)       req.action = ACT_INIT;
    else if (pick < 30) req.action = ACT_CMD;
    else if (pick < 58) req.action = ACT_DATA;
    else if (pick < 68) req.action = ACT_CLEAR;
    else if (pick < 90) req.action = ACT_CURSOR;
    else                req.action = 3'($urandom_range(7, 5));
    push_request(req);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (book.due_writes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    book.set_reg(idx, value);
  endtask

  task automatic load_timing(input logic [7:0] pulse, input logic [7:0] gap,
                             input logic [7:0] power);
    write_reg(CFG_ENABLE_PULSE, pulse);
    write_reg(CFG_NIBBLE_GAP, gap);
    write_reg(CFG_POWER_UP, power);
    write_reg(CfgSpare, 8'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    book         = new();
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_item_i    = '0;
    out_stall_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    stuck_cycles = 0;
    in_idle_pct  = IdlePct;
    out_idle_pct = IdlePct;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    make_request(ACT_INIT, 8'h00, 6'd0, 2'd0);
    make_request(ACT_CMD, 8'h00, 6'd0, 2'd0);
    make_request(ACT_CMD, 8'hFF, 6'd63, 2'd3);
    make_request(ACT_DATA, 8'h00, 6'd0, 2'd0);
    make_request(ACT_DATA, 8'hFF, 6'd63, 2'd1);
    make_request(ACT_DATA, 8'hA5, 6'd21, 2'd2);
    make_request(ACT_CLEAR, 8'hFF, 6'd63, 2'd3);
    make_request(ACT_CURSOR, 8'h00, 6'd0, 2'd0);
    make_request(ACT_CURSOR, 8'hFF, 6'd63, 2'd1);
    make_request(ACT_CURSOR, 8'h00, 6'd0, 2'd1);
    make_request(ACT_CURSOR, 8'h55, 6'd63, 2'd2);
    make_request(ACT_CURSOR, 8'hAA, 6'd42, 2'd3);
    make_request(3'd5, 8'hFF, 6'd63, 2'd3);
    make_request(3'd6, 8'h00, 6'd0, 2'd0);
    make_request(3'd7, 8'h5A, 6'd17, 2'd1);
    make_request(ACT_INIT, 8'hFF, 6'd63, 2'd3);
    make_request(ACT_CMD, 8'h5A, 6'd1, 2'd2);
    settle();

    for (int phase = 0; phase < 6; phase++) begin
      in_idle_pct  = (phase == 1) ? 0 : IdlePct;
      out_idle_pct = (phase == 1) ? 0 : IdlePct;
      case (phase)
        0: load_timing(8'd0, 8'd0, 8'd0);
        1: load_timing(8'd255, 8'd255, 8'd255);
        4: load_timing(8'd1, 8'd100, 8'd20);
        default: load_timing(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      repeat (67) push_random_request();
      settle();
    end

    if (book.mismatches == 0 && book.due_writes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/cnls_pkg.sv
src/cnls_front.sv
src/cnls_queue.sv
src/cnls_back.sv
src/char_lcd_nibble_sequencer_core.sv
src/cnls_checker.sv
dv/tb_top.sv
